FILE: rtl/mbss_pkg.sv
// package for the masked byte signature scanner
// request payload types, register indexes, result kinds and default sizes
// no dependencies
package mbss_pkg;

    // default sizes for the top-level parameters
    localparam int MAX_LEN_DEF    = 32;
    localparam int POS_BITS_DEF   = 32;
    localparam int COUNT_BITS_DEF = 16;

    // fixed pattern storage and configuration port widths
    localparam int PATTERN_BYTES = 32;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_0   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_1   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_2   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_3   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MATCH_MASK  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LEN = 3'd5;

    // result kinds
    localparam logic KIND_MATCH   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // pattern bytes, byte 0 in the low bits
    typedef logic [PATTERN_BYTES-1:0][7:0] pattern_t;

    // input request payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_region;
        logic       end_of_scan;
    } in_item_t;

    // result request payload
    typedef struct packed {
        logic        result_kind;
        logic [31:0] match_offset;
        logic [15:0] match_count;
        logic        unique_match;
        logic        last_result;
    } result_t;

endpackage

FILE: rtl/mbss_chan_if.sv
// valid/ready channel carrying one request payload
// depends on mbss_pkg for the payload types used by the instances
interface mbss_chan_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

FILE: rtl/mbss_cell.sv
// one window cell: holds one byte of the window and its in-region flag
// compares its byte against the pattern byte aligned to its age; uses mbss_pkg
module mbss_cell #(
    parameter int IDX   = 0,
    parameter int LEN_W = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   shift_en,
    input  logic                   flush,
    input  logic [7:0]             byte_in,
    input  logic                   vld_in,
    input  mbss_pkg::pattern_t     pattern,
    input  logic [31:0]            match_mask,
    input  logic [LEN_W-1:0]       len_m1,
    output logic [7:0]             byte_out,
    output logic                   vld_out,
    output logic                   ok
);
    import mbss_pkg::*;

    localparam int JW = (LEN_W > 5) ? LEN_W : 6;

    logic [7:0]    byte_reg;
    logic          vld_reg;
    logic [JW-1:0] pat_idx;
    logic          in_use;
    logic          beyond;
    logic          byte_ok;

    // window byte, shifted in from the younger neighbor
    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            byte_reg <= byte_in;
        end
    end

    // in-region flag, dropped when the previous request closed the region
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            vld_reg <= vld_in & ~flush;
        end
    end

    // pattern byte for this age is len-1-age
    always_comb
    begin
        pat_idx = JW'(len_m1) - JW'(IDX);
        in_use  = JW'(IDX) <= JW'(len_m1);
        beyond  = pat_idx[JW-1:5] != '0;
        byte_ok = beyond || !match_mask[pat_idx[4:0]] ||
                  (byte_reg == pattern[pat_idx[4:0]]);
        ok      = !in_use || (vld_reg && byte_ok);
    end

    assign byte_out = byte_reg;
    assign vld_out  = vld_reg;

endmodule

FILE: rtl/mbss_result_queue.sv
// two-entry result queue, takes up to two results in one cycle
// depends on mbss_pkg for result_t
module mbss_result_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_cnt,
    input  mbss_pkg::result_t push_a,
    input  mbss_pkg::result_t push_b,
    output logic [1:0]        space,
    output logic              out_valid,
    input  logic              out_ready,
    output mbss_pkg::result_t out_payload
);
    import mbss_pkg::*;

    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic [1:0] count_reg, count_next;
    logic       pop;
    logic [1:0] remain;

    assign pop         = out_valid && out_ready;
    assign out_valid   = count_reg != 2'd0;
    assign out_payload = slot0_reg;
    assign space       = 2'd2 - count_reg + {1'b0, pop};

    // compact after pop, then append pushed results
    always_comb
    begin
        remain     = count_reg - {1'b0, pop};
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case (remain)
            2'd0:
            begin
                slot0_next = push_a;
                slot1_next = push_b;
            end
            2'd1:
            begin
                slot0_next = pop ? slot1_reg : slot0_reg;
                slot1_next = push_a;
            end
            default:
            begin
                slot0_next = slot0_reg;
                slot1_next = slot1_reg;
            end
        endcase
        count_next = remain + push_cnt;
    end

    // result slots
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

FILE: rtl/masked_byte_signature_scanner.sv
// masked byte signature scanner: one byte request per cycle while the result queue has room, no gaps needed
// path: an accepted byte is registered in the window cells, then its results are pushed into the result queue
// throughput: one byte per cycle while the result queue has room; a byte that
//   gives both a match and the scan summary sends two results, which leave the queue one at a time
// reset: registers, control flags and counters clear at once, window bytes
//   keep their value but all cells are marked out of region
module masked_byte_signature_scanner #(
    parameter int MAX_LEN    = mbss_pkg::MAX_LEN_DEF,
    parameter int POS_BITS   = mbss_pkg::POS_BITS_DEF,
    parameter int COUNT_BITS = mbss_pkg::COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [mbss_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mbss_pkg::CFG_DATA_W-1:0]    cfg_data,
    mbss_chan_if.sink                          in_chan,
    mbss_chan_if.source                        out_chan
);
    import mbss_pkg::*;

    localparam int LEN_W = $clog2(MAX_LEN);

    // configuration registers
    logic [63:0]       pat_reg [4];
    logic [31:0]       mask_reg;
    logic [5:0]        len_reg;
    pattern_t          pattern;
    logic [6:0]        len_ext;
    logic [LEN_W-1:0]  len_m1;

    // cell row
    logic [7:0]        byte_chain [MAX_LEN];
    logic              vld_chain  [MAX_LEN];
    logic [MAX_LEN-1:0] ok_vec;

    // pipeline and scan state
    logic                  flush_reg;
    logic [POS_BITS-1:0]   scan_pos_reg, scan_pos_next;
    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_eos_reg;
    logic [POS_BITS-1:0]   s1_pos_reg;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [POS_BITS-1:0]   latest_reg, latest_next;

    // result path
    logic                  accept;
    logic                  retire;
    logic                  hit;
    logic [1:0]            n_res;
    logic [1:0]            space;
    logic [1:0]            push_cnt;
    logic [POS_BITS-1:0]   match_off;
    logic [COUNT_BITS-1:0] count_after;
    logic [POS_BITS-1:0]   latest_after;
    logic [POS_BITS+31:0]  off_ext;
    logic [POS_BITS+31:0]  last_ext;
    logic [COUNT_BITS+15:0] cnt_ext;
    logic [15:0]           cnt_out;
    result_t               match_res;
    result_t               summary_res;
    result_t               push_a;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg[0] <= '0;
            pat_reg[1] <= '0;
            pat_reg[2] <= '0;
            pat_reg[3] <= '0;
            mask_reg   <= '0;
            len_reg    <= 6'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_0:   pat_reg[0] <= cfg_data;
                REG_PATTERN_1:   pat_reg[1] <= cfg_data;
                REG_PATTERN_2:   pat_reg[2] <= cfg_data;
                REG_PATTERN_3:   pat_reg[3] <= cfg_data;
                REG_MATCH_MASK:  mask_reg   <= cfg_data[31:0];
                REG_PATTERN_LEN: len_reg    <= cfg_data[5:0];
                default:         ;
            endcase
        end
    end

    assign pattern = {pat_reg[3], pat_reg[2], pat_reg[1], pat_reg[0]};

    // clamp the pattern length to 1..MAX_LEN, kept as length minus one
    always_comb
    begin
        len_ext = {1'b0, len_reg};
        if (len_reg == 6'd0)
        begin
            len_m1 = '0;
        end
        else if (len_ext > 7'(MAX_LEN))
        begin
            len_m1 = LEN_W'(MAX_LEN - 1);
        end
        else
        begin
            len_m1 = LEN_W'(len_ext - 7'd1);
        end
    end

    // handshake
    assign in_chan.ready = !s1_valid_reg || retire;
    assign accept        = in_chan.valid && in_chan.ready;

    // row of window cells, youngest byte in cell 0
    for (genvar g = 0; g < MAX_LEN; g++)
    begin : g_cell
        logic [7:0] byte_in;
        logic       vld_in;
        logic       flush_in;

        if (g == 0)
        begin : g_head
            assign byte_in  = in_chan.payload.data_byte;
            assign vld_in   = 1'b1;
            assign flush_in = 1'b0;
        end
        else
        begin : g_body
            assign byte_in  = byte_chain[g-1];
            assign vld_in   = vld_chain[g-1];
            assign flush_in = flush_reg;
        end

        mbss_cell #(
            .IDX   (g),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (accept),
            .flush      (flush_in),
            .byte_in    (byte_in),
            .vld_in     (vld_in),
            .pattern    (pattern),
            .match_mask (mask_reg),
            .len_m1     (len_m1),
            .byte_out   (byte_chain[g]),
            .vld_out    (vld_chain[g]),
            .ok         (ok_vec[g])
        );
    end

    // accept stage: position tracking and region close flag
    always_comb
    begin
        scan_pos_next = scan_pos_reg;
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            scan_pos_next = in_chan.payload.end_of_scan ? '0 : scan_pos_reg + 1'b1;
            s1_valid_next = 1'b1;
        end
        else if (retire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_reg    <= 1'b0;
            scan_pos_reg <= '0;
            s1_valid_reg <= 1'b0;
            s1_eos_reg   <= 1'b0;
        end
        else
        begin
            scan_pos_reg <= scan_pos_next;
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                flush_reg  <= in_chan.payload.end_of_region | in_chan.payload.end_of_scan;
                s1_eos_reg <= in_chan.payload.end_of_scan;
            end
        end
    end

    // position of the byte in the window stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pos_reg <= scan_pos_reg;
        end
    end

    // match decision and result building
    always_comb
    begin
        hit       = &ok_vec;
        n_res     = {1'b0, hit} + {1'b0, s1_eos_reg};
        retire    = s1_valid_reg && (space >= n_res);
        match_off = s1_pos_reg - POS_BITS'(len_m1);

        count_after  = (hit && !(&count_reg)) ? count_reg + 1'b1 : count_reg;
        latest_after = hit ? match_off : latest_reg;

        off_ext  = {32'd0, match_off};
        last_ext = {32'd0, latest_after};
        cnt_ext  = {16'd0, count_after};
        cnt_out  = (cnt_ext[COUNT_BITS+15:16] != '0) ? 16'hFFFF : cnt_ext[15:0];

        match_res.result_kind  = KIND_MATCH;
        match_res.match_offset = off_ext[31:0];
        match_res.match_count  = 16'd0;
        match_res.unique_match = 1'b0;
        match_res.last_result  = !s1_eos_reg;

        summary_res.result_kind  = KIND_SUMMARY;
        summary_res.match_offset = last_ext[31:0];
        summary_res.match_count  = cnt_out;
        summary_res.unique_match = count_after == COUNT_BITS'(1);
        summary_res.last_result  = 1'b1;

        push_a   = hit ? match_res : summary_res;
        push_cnt = retire ? n_res : 2'd0;

        count_next  = count_reg;
        latest_next = latest_reg;
        if (retire)
        begin
            count_next  = s1_eos_reg ? '0 : count_after;
            latest_next = s1_eos_reg ? '0 : latest_after;
        end
    end

    // match count and last offset of the running scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            latest_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            latest_reg <= latest_next;
        end
    end

    // output queue
    mbss_result_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_cnt    (push_cnt),
        .push_a      (push_a),
        .push_b      (summary_res),
        .space       (space),
        .out_valid   (out_chan.valid),
        .out_ready   (out_chan.ready),
        .out_payload (out_chan.payload)
    );

endmodule

FILE: rtl/mbss_checker.sv
// port-level checks for the masked byte signature scanner
// depends on mbss_pkg; bound to masked_byte_signature_scanner below
module mbss_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              out_valid,
    input  logic              out_ready,
    input  mbss_pkg::result_t out_payload
);
    import mbss_pkg::*;

    // a pending result request stays up until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result request dropped before it was taken");

    // the summary always closes the results of its byte
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.result_kind == KIND_SUMMARY |-> out_payload.last_result)
        else $error("summary without last_result");

    // a match report carries no count and no unique flag
    a_match_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.result_kind == KIND_MATCH |->
            out_payload.match_count == 16'd0 && !out_payload.unique_match)
        else $error("match report with summary fields set");

    // unique flag agrees with a count of one
    a_unique_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.result_kind == KIND_SUMMARY |->
            out_payload.unique_match == (out_payload.match_count == 16'd1))
        else $error("unique flag disagrees with match count");

endmodule

bind masked_byte_signature_scanner mbss_checker u_mbss_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_chan.valid),
    .out_ready   (out_chan.ready),
    .out_payload (out_chan.payload)
);

FILE: tb/tb.sv
// self-checking bench for masked_byte_signature_scanner: directed scans, random register
// settings with planted patterns, output backpressure and an unbroken request stream
// depends on mbss_pkg, mbss_chan_if and the scanner rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbss_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int WINDOW_BYTES   = MAX_LEN_DEF;
    localparam int DRAIN_CYCLES   = 6;
    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int IDLE_PERCENT   = 12;
    localparam int PHASE_BYTES    = 60;
    localparam int STREAM_BYTES   = 100;

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_7 = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    mbss_chan_if #(.payload_t(in_item_t)) byte_chan ();
    mbss_chan_if #(.payload_t(result_t))  report_chan ();

    masked_byte_signature_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_chan   (byte_chan),
        .out_chan  (report_chan)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // scanner copy: registers and scan state
    logic [63:0] pat_word [4];
    logic [31:0] match_mask_reg;
    logic [5:0]  pattern_len_reg;
    logic [7:0]  window_bytes [WINDOW_BYTES];
    int unsigned window_fill;
    logic [31:0] scan_pos;
    logic [15:0] hit_count;
    logic [31:0] last_hit_offset;
    result_t     pending_reports [$];

    // run control and bookkeeping
    bit          sender_idles   = 1'b1;
    bit          receiver_idles = 1'b1;
    bit          hold_off_request = 1'b0;
    int unsigned hold_left = 0;
    int unsigned scan_left = 0;
    int unsigned stall_cycles = 0;
    int unsigned error_count = 0;
    int unsigned bytes_accepted = 0;
    int unsigned match_reports_seen = 0;
    int unsigned summaries_seen = 0;
    int unsigned settings_used = 0;

    function automatic int unsigned eff_pattern_len();
        if (pattern_len_reg == 0)
            return 1;
        if (pattern_len_reg > WINDOW_BYTES)
            return WINDOW_BYTES;
        return 32'(pattern_len_reg);
    endfunction

    function automatic logic [7:0] pattern_byte(input int unsigned j);
        return pat_word[j[4:3]][(j & 7) * 8 +: 8];
    endfunction

    // shift one byte in, test the window ending here, queue the reports it owes
    function automatic void scan_one_byte(input in_item_t item);
        int unsigned plen;
        int          j;
        bit          hit;
        result_t     rep;
        plen = eff_pattern_len();
        for (j = WINDOW_BYTES - 1; j > 0; j--)
            window_bytes[j] = window_bytes[j - 1];
        window_bytes[0] = item.data_byte;
        if (window_fill < WINDOW_BYTES)
            window_fill++;
        hit = (window_fill >= plen);
        for (j = 0; j < plen; j++)
            if (match_mask_reg[j] && window_bytes[plen - 1 - j] != pattern_byte(j))
                hit = 1'b0;
        if (hit)
        begin
            last_hit_offset = scan_pos - (plen - 1);
            if (hit_count != '1)
                hit_count++;
            rep.result_kind  = KIND_MATCH;
            rep.match_offset = last_hit_offset;
            rep.match_count  = '0;
            rep.unique_match = 1'b0;
            rep.last_result  = !item.end_of_scan;
            pending_reports.push_back(rep);
        end
        scan_pos++;
        if (item.end_of_region || item.end_of_scan)
            window_fill = 0;
        // scan end: summary, then a fresh scan at position 0
        if (item.end_of_scan)
        begin
            rep.result_kind  = KIND_SUMMARY;
            rep.match_offset = last_hit_offset;
            rep.match_count  = hit_count;
            rep.unique_match = (hit_count == 1);
            rep.last_result  = 1'b1;
            pending_reports.push_back(rep);
            hit_count       = '0;
            last_hit_offset = '0;
            scan_pos        = '0;
        end
    endfunction

    // compare one report from the scanner with the oldest one owed
    function automatic void compare_report(input result_t got);
        result_t want;
        if (pending_reports.size() == 0)
        begin
            $error("unexpected report: kind %0d offset %0d count %0d",
                   got.result_kind, got.match_offset, got.match_count);
            error_count++;
            return;
        end
        want = pending_reports.pop_front();
        if (want.result_kind == KIND_MATCH)
            match_reports_seen++;
        else
            summaries_seen++;
        if (got.result_kind !== want.result_kind)
        begin
            $error("result_kind: expected %0d, got %0d", want.result_kind, got.result_kind);
            error_count++;
        end
        if (got.match_offset !== want.match_offset)
        begin
            $error("match_offset: expected %0d, got %0d", want.match_offset, got.match_offset);
            error_count++;
        end
        if (got.match_count !== want.match_count)
        begin
            $error("match_count: expected %0d, got %0d", want.match_count, got.match_count);
            error_count++;
        end
        if (got.unique_match !== want.unique_match)
        begin
            $error("unique_match: expected %0d, got %0d", want.unique_match, got.unique_match);
            error_count++;
        end
        if (got.last_result !== want.last_result)
        begin
            $error("last_result: expected %0d, got %0d", want.last_result, got.last_result);
            error_count++;
        end
    endfunction

    // accepted requests on both channels, plus the stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_chan.valid && byte_chan.ready)
            begin
                scan_one_byte(byte_chan.payload);
                bytes_accepted++;
            end
            if (report_chan.valid && report_chan.ready)
                compare_report(report_chan.payload);
            if ((byte_chan.valid && byte_chan.ready) || (report_chan.valid && report_chan.ready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("masked_byte_signature_scanner: mismatch");
                    $finish;
                end
            end
        end
    end

    // report receiver: random stalls, or a long hold-off on request
    initial
    begin
        report_chan.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                report_chan.ready <= 1'b0;
                hold_left--;
            end
            else
                report_chan.ready <= !(receiver_idles && $urandom_range(99) < IDLE_PERCENT);
        end
    end

    // offer one byte request, valid stays high into the next request
    task automatic send_byte(input logic [7:0] d, input logic eor, input logic eos);
        in_item_t item;
        item.data_byte     = d;
        item.end_of_region = eor;
        item.end_of_scan   = eos;
        while (sender_idles && $urandom_range(99) < IDLE_PERCENT)
        begin
            byte_chan.valid <= 1'b0;
            @(posedge clk);
        end
        byte_chan.valid   <= 1'b1;
        byte_chan.payload <= item;
        do
            @(posedge clk);
        while (!byte_chan.ready);
    endtask

    // let every owed report out, then give the pipeline time to go quiet
    task automatic drain_scanner();
        byte_chan.valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PATTERN_0:   pat_word[0] = value;
            REG_PATTERN_1:   pat_word[1] = value;
            REG_PATTERN_2:   pat_word[2] = value;
            REG_PATTERN_3:   pat_word[3] = value;
            REG_MATCH_MASK:  match_mask_reg = value[31:0];
            REG_PATTERN_LEN:
            begin
                pattern_len_reg = value[5:0];
                settings_used++;
            end
            default: ;
        endcase
        @(posedge clk);
    endtask

    // next byte of the current scan, the last one closes the scan
    task automatic emit_scan_byte(input logic [7:0] d);
        send_byte(d, $urandom_range(99) < 4, scan_left == 1);
        scan_left--;
    endtask

    // one scan: mostly planted patterns, some with a corrupted byte, some noise runs
    task automatic run_random_scan(input int unsigned n_bytes);
        int unsigned plen;
        int unsigned j;
        int unsigned flip;
        int unsigned r;
        logic [7:0]  d;
        plen = eff_pattern_len();
        scan_left = n_bytes;
        while (scan_left > 0)
        begin
            r = $urandom_range(9);
            if (r < 8)
            begin
                flip = (r >= 6) ? $urandom_range(plen - 1) : plen;
                for (j = 0; j < plen && scan_left > 0; j++)
                begin
                    d = match_mask_reg[j] ? pattern_byte(j) : 8'($urandom_range(255));
                    if (j == flip)
                        d = d ^ 8'($urandom_range(1, 255));
                    emit_scan_byte(d);
                end
            end
            else
                repeat ($urandom_range(1, 6))
                    if (scan_left > 0)
                        emit_scan_byte(8'($urandom_range(255)));
        end
    endtask

    // reset settings: length 1, nothing compared, every byte is a match
    task automatic test_reset_defaults();
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'ha5, 1'b0, 1'b1);
        send_byte(8'h3c, 1'b1, 1'b1);
    endtask

    // the only full window differs in its last byte, summary reports all zeros
    task automatic test_no_match();
        drain_scanner();
        write_reg(REG_PATTERN_0, 64'h0000_0000_0033_2211);
        write_reg(REG_MATCH_MASK, 64'h7);
        write_reg(REG_PATTERN_LEN, 64'd3);
        send_byte(8'h11, 1'b0, 1'b0);
        send_byte(8'h22, 1'b0, 1'b0);
        send_byte(8'h34, 1'b0, 1'b1);
    endtask

    // overlapping hits, and a window across a region end that must not hit
    task automatic test_overlap_and_regions();
        drain_scanner();
        write_reg(REG_PATTERN_0, 64'h0000_0000_0000_aaaa);
        write_reg(REG_MATCH_MASK, 64'h3);
        write_reg(REG_PATTERN_LEN, 64'd2);
        send_byte(8'haa, 1'b0, 1'b0);
        send_byte(8'haa, 1'b0, 1'b0);
        send_byte(8'haa, 1'b1, 1'b0);
        send_byte(8'haa, 1'b0, 1'b0);
        send_byte(8'haa, 1'b0, 1'b1);
    endtask

    // zero length acts as one, then writes to unused indexes change nothing
    task automatic test_length_and_bad_index();
        drain_scanner();
        write_reg(REG_PATTERN_0, 64'h5a);
        write_reg(REG_MATCH_MASK, 64'h1);
        write_reg(REG_PATTERN_LEN, 64'd0);
        send_byte(8'h5a, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h5a, 1'b0, 1'b1);
        drain_scanner();
        write_reg(REG_UNUSED_6, '1);
        write_reg(REG_UNUSED_7, '1);
        send_byte(8'h5a, 1'b0, 1'b1);
    endtask

    // random pattern, mask and length per phase, extremes of length included
    task automatic test_random_settings();
        int unsigned p;
        int unsigned done;
        int unsigned n;
        logic [31:0] mask;
        logic [5:0]  plen;
        for (p = 0; p < 8; p++)
        begin
            drain_scanner();
            case (p % 4)
                0: mask = '1;
                1: mask = $urandom;
                2: mask = $urandom & $urandom;
                default: mask = '0;
            endcase
            case (p)
                0: plen = 6'd32;
                1: plen = 6'd63;
                2: plen = 6'd0;
                3: plen = 6'd1;
                4: plen = 6'd33;
                default: plen = 6'($urandom_range(2, 8));
            endcase
            write_reg(REG_PATTERN_0, {$urandom, $urandom});
            write_reg(REG_PATTERN_1, {$urandom, $urandom});
            write_reg(REG_PATTERN_2, {$urandom, $urandom});
            write_reg(REG_PATTERN_3, {$urandom, $urandom});
            write_reg(REG_MATCH_MASK, {32'h0, mask});
            write_reg(REG_PATTERN_LEN, {58'h0, plen});
            done = 0;
            while (done < PHASE_BYTES)
            begin
                n = $urandom_range(8, 40);
                run_random_scan(n);
                done += n;
            end
        end
    endtask

    // every byte hits while the receiver holds off, so the input has to stall
    task automatic test_output_backpressure();
        drain_scanner();
        write_reg(REG_MATCH_MASK, 64'h0);
        write_reg(REG_PATTERN_LEN, 64'd1);
        hold_off_request = 1'b1;
        run_random_scan(60);
    endtask

    // every byte hits, one scan with no idling on either side
    task automatic test_unbroken_stream();
        drain_scanner();
        write_reg(REG_MATCH_MASK, 64'h0);
        write_reg(REG_PATTERN_LEN, 64'd1);
        sender_idles   = 1'b0;
        receiver_idles = 1'b0;
        scan_left = STREAM_BYTES;
        while (scan_left > 0)
            emit_scan_byte(8'($urandom_range(255)));
        drain_scanner();
        sender_idles   = 1'b1;
        receiver_idles = 1'b1;
    endtask

    initial
    begin
        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        byte_chan.valid   <= 1'b0;
        byte_chan.payload <= '0;
        // scanner copy starts from reset values
        for (int k = 0; k < 4; k++)
            pat_word[k] = '0;
        for (int k = 0; k < WINDOW_BYTES; k++)
            window_bytes[k] = '0;
        match_mask_reg  = '0;
        pattern_len_reg = 6'd1;
        window_fill     = 0;
        scan_pos        = '0;
        hit_count       = '0;
        last_hit_offset = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_no_match();
        test_overlap_and_regions();
        test_length_and_bad_index();
        test_random_settings();
        test_output_backpressure();
        test_unbroken_stream();
        drain_scanner();

        $display("scanned %0d bytes under %0d length settings", bytes_accepted, settings_used);
        $display("checked %0d match reports and %0d scan summaries",
                 match_reports_seen, summaries_seen);
        if (error_count == 0)
            $display("masked_byte_signature_scanner: match");
        else
            $display("masked_byte_signature_scanner: mismatch");
        $finish;
    end

endmodule
